@@ design/mws_pkg.sv @@
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types, widths and register codes of the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
package mws_pkg;

    localparam int XY_W      = 12;   // chassis x / y speed
    localparam int YAW_W     = 13;   // yaw rate, Q4.8
    localparam int MOT_W     = 26;   // motor rpm before the final clamp
    localparam int QUO_W     = 25;   // magnitude of a rescaled target
    localparam int DIV_STEPS = QUO_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GEOMETRY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 8'd3;

    localparam logic [7:0]  GEOMETRY_RST = 8'd40;
    localparam logic [15:0] GAIN_RST     = 16'd5160;
    localparam logic [15:0] RATIO_RST    = 16'd4916;
    localparam logic [13:0] LIMIT_RST    = 14'd8000;

    typedef logic signed [MOT_W-1:0] mot_t;

    typedef struct packed {
        logic [7:0]  geometry;
        logic [15:0] gain;
        logic [15:0] ratio;
        logic [13:0] limit;
    } cfg_t;

    // One wheel lane inside the restoring divider.
    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic             neg;
        mot_t             mot;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [3:0]  lane;
        logic [QUO_W-1:0] divisor;
        logic             limited;
    } div_item_t;

endpackage

@@ design/mws_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mws_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mws_cfg_regs
    import mws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.geometry <= GEOMETRY_RST;
            cfg_reg.gain     <= GAIN_RST;
            cfg_reg.ratio    <= RATIO_RST;
            cfg_reg.limit    <= LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GEOMETRY: cfg_reg.geometry <= cfg_data[7:0];
                CFG_GAIN:     cfg_reg.gain     <= cfg_data;
                CFG_RATIO:    cfg_reg.ratio    <= cfg_data;
                CFG_LIMIT:    cfg_reg.limit    <= cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/mws_kin.sv @@
// ----------------------------------------------------------------------------
// mws_kin
// Six-stage mixing and scaling: wheel speeds, wheel rpm, motor rpm.
// ----------------------------------------------------------------------------
module mws_kin
    import mws_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    input  logic signed [XY_W-1:0]  in_x,
    input  logic signed [XY_W-1:0]  in_y,
    input  logic signed [YAW_W-1:0] in_yaw,
    output logic                    out_valid,
    output mot_t                    out_mot [4]
);

    logic [5:0] valid_reg;

    logic signed [XY_W:0] sum_reg, dif_reg;
    logic signed [21:0]   rot_reg;
    logic signed [21:0]   lin_reg  [4];
    logic signed [38:0]   prod_reg [4];
    mot_t                 whl_reg  [4];
    logic signed [42:0]   prod2_reg[4];
    mot_t                 mot_reg  [4];

    logic signed [21:0] sum_s, dif_s;
    logic signed [38:0] prod_adj [4];
    logic signed [42:0] prod2_adj[4];

    always_comb begin
        sum_s = {sum_reg[XY_W], sum_reg, 8'b0};
        dif_s = {dif_reg[XY_W], dif_reg, 8'b0};
        for (int i = 0; i < 4; i++) begin
            // truncate toward zero: bias negatives before the shift
            prod_adj[i]  = prod_reg[i] + {27'b0, {12{prod_reg[i][38]}}};
            prod2_adj[i] = prod2_reg[i] + {27'b0, {16{prod2_reg[i][42]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= {in_x[XY_W-1], in_x} + {in_y[XY_W-1], in_y};
            dif_reg <= {in_x[XY_W-1], in_x} - {in_y[XY_W-1], in_y};
            rot_reg <= in_yaw * $signed({1'b0, cfg.geometry});

            lin_reg[0] <= sum_s + rot_reg;
            lin_reg[1] <= dif_s - rot_reg;
            lin_reg[2] <= dif_s + rot_reg;
            lin_reg[3] <= sum_s - rot_reg;

            for (int i = 0; i < 4; i++) begin
                prod_reg[i]  <= lin_reg[i] * $signed({1'b0, cfg.gain});
                whl_reg[i]   <= prod_adj[i][37:12];
                prod2_reg[i] <= whl_reg[i] * $signed({1'b0, cfg.ratio});
            end

            mot_reg[0] <= prod2_adj[0][41:16];
            mot_reg[1] <= -prod2_adj[1][41:16];
            mot_reg[2] <= prod2_adj[2][41:16];
            mot_reg[3] <= -prod2_adj[3][41:16];
        end
    end

    assign out_valid = valid_reg[5];
    assign out_mot   = mot_reg;

endmodule

@@ design/mws_limit.sv @@
// ----------------------------------------------------------------------------
// mws_limit
// Signed maximum, limit compare and dividend setup for the rescale.
// ----------------------------------------------------------------------------
module mws_limit
    import mws_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  cfg_t      cfg,
    input  logic      in_valid,
    input  mot_t      in_mot [4],
    output logic      out_valid,
    output div_item_t out_item
);

    logic [1:0]         valid_reg;
    mot_t               mot_reg  [4];
    logic signed [40:0] prd_reg  [4];
    mot_t               max_a_reg, max_b_reg;
    div_item_t          item_reg;

    mot_t               max_all;
    logic signed [40:0] prd_abs [4];
    div_item_t          item_next;

    always_comb begin
        max_all = (max_b_reg > max_a_reg) ? max_b_reg : max_a_reg;
        item_next.limited = max_all > $signed({12'b0, cfg.limit});
        item_next.divisor = max_all[QUO_W-1:0];
        for (int i = 0; i < 4; i++) begin
            prd_abs[i] = prd_reg[i][40] ? -prd_reg[i] : prd_reg[i];
            item_next.lane[i].neg = prd_reg[i][40];
            item_next.lane[i].rem = {11'b0, prd_abs[i][38:25]};
            item_next.lane[i].num = prd_abs[i][24:0];
            item_next.lane[i].quo = '0;
            item_next.lane[i].mot = mot_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                mot_reg[i] <= in_mot[i];
                prd_reg[i] <= in_mot[i] * $signed({1'b0, cfg.limit});
            end
            max_a_reg <= (in_mot[1] > in_mot[0]) ? in_mot[1] : in_mot[0];
            max_b_reg <= (in_mot[3] > in_mot[2]) ? in_mot[3] : in_mot[2];
            item_reg  <= item_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_item  = item_reg;

endmodule

@@ design/mws_div.sv @@
// ----------------------------------------------------------------------------
// mws_div
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mws_div
    import mws_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output div_item_t out_item
);

    function automatic div_item_t div_step(input div_item_t cur);
        div_item_t      nxt;
        logic [QUO_W:0] trial;
        logic           ge;
        nxt = cur;
        for (int i = 0; i < 4; i++) begin
            trial = {cur.lane[i].rem, cur.lane[i].num[QUO_W-1]};
            ge    = trial >= {1'b0, cur.divisor};
            nxt.lane[i].rem = ge ? QUO_W'(trial - {1'b0, cur.divisor})
                                 : trial[QUO_W-1:0];
            nxt.lane[i].num = {cur.lane[i].num[QUO_W-2:0], 1'b0};
            nxt.lane[i].quo = {cur.lane[i].quo[QUO_W-2:0], ge};
        end
        return nxt;
    endfunction

    logic [DIV_STEPS-1:0] valid_reg;
    div_item_t            stage_reg [DIV_STEPS];
    div_item_t            stage_in  [DIV_STEPS];

    always_comb begin
        stage_in[0] = in_item;
        for (int k = 1; k < DIV_STEPS; k++) begin
            stage_in[k] = stage_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                stage_reg[k] <= div_step(stage_in[k]);
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_item  = stage_reg[DIV_STEPS-1];

endmodule

@@ design/mecanum_wheel_speed_mixer.sv @@
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Mecanum inverse kinematics: chassis command in, four motor rpm targets out.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  --------------------------------------
//  s_       in   s_tvalid / s_tready   speed_x, speed_y, yaw_rate
//  m_       out  m_tvalid / m_tready   four motor targets; tuser = limited
//  cfg_     in   cfg_valid/cfg_ready   register index, write data
//
//  One request per cycle while not stalled, through 6 scaling stages,
//  2 limit stages, 25 divider stages (one quotient bit each), output register.
//  The divider pipeline sets the latency; every stage is fully pipelined.
//  Stall: the whole pipe holds while the output register is full and not
//  taken; s_tready follows that, so nothing is dropped or duplicated.
//  Reset (aresetn low, synchronous) clears valid bits and loads default config.
//
module mecanum_wheel_speed_mixer
    import mws_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // speed_x[11:0], speed_y[23:12],
                                            // yaw_rate[36:24], zero pad
    // result out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // motor_one[15:0], motor_two[31:16],
                                            // motor_three[47:32], motor_four[63:48]
    output logic [0:0]           m_tuser,   // limited
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t      cfg;
    logic      adv;
    logic      kin_valid, lim_valid, div_valid;
    mot_t      kin_mot [4];
    div_item_t lim_item, div_item;

    logic         out_valid_reg;
    logic [63:0]  out_data_reg;
    logic         out_lim_reg;
    logic [63:0]  out_data_next;

    // Everything moves together unless the output slot is blocked.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    mws_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mws_kin u_kin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_x      (s_tdata[11:0]),
        .in_y      (s_tdata[23:12]),
        .in_yaw    (s_tdata[36:24]),
        .out_valid (kin_valid),
        .out_mot   (kin_mot)
    );

    mws_limit u_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (kin_valid),
        .in_mot    (kin_mot),
        .out_valid (lim_valid),
        .out_item  (lim_item)
    );

    mws_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (lim_valid),
        .in_item   (lim_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // Final select: rescaled quotient (sign restored) or untouched target,
    // then clamp to 16 bits.
    always_comb begin
        logic signed [MOT_W-1:0] quo_s;
        logic signed [MOT_W-1:0] val;
        out_data_next = '0;
        for (int i = 0; i < 4; i++) begin
            quo_s = div_item.lane[i].neg ? -$signed({1'b0, div_item.lane[i].quo})
                                         :  $signed({1'b0, div_item.lane[i].quo});
            val   = div_item.limited ? quo_s : div_item.lane[i].mot;
            if (val > 26'sd32767) begin
                out_data_next[16*i +: 16] = 16'h7fff;
            end else if (val < -26'sd32768) begin
                out_data_next[16*i +: 16] = 16'h8000;
            end else begin
                out_data_next[16*i +: 16] = val[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_lim_reg  <= div_item.limited;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_lim_reg;

endmodule
